### hw/rtl/ttcb_pkg.sv
// shared types, constants and the quarter-wave sine table for the ttc brake block
// no dependencies
`default_nettype none
package ttcb_pkg;

	localparam int TrigDepth = 256;
	localparam int TrigIdxW = $clog2(TrigDepth + 1);
	localparam int TrigProdW = 15 + TrigIdxW;

	localparam logic [16:0] TtcCapMs = 17'd100000;
	localparam int NumW = 41;
	localparam int DivW = 32;
	localparam int DivSteps = NumW;
	localparam int DivCntW = $clog2(DivSteps);

	localparam logic [1:0] RegAngleStart = 2'd0;
	localparam logic [1:0] RegAngleStep = 2'd1;
	localparam logic [1:0] RegThreshold = 2'd2;

	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

	typedef logic [15:0] sine_tab_t [0:TrigDepth];

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIG,
		ST_MUL,
		ST_SUM,
		ST_DINIT,
		ST_DIV,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic trig;
		logic mul;
		logic sum;
		logic dinit;
		logic dstep;
		logic upd;
	} cmd_t;

	typedef struct packed {
		logic use_div;
		logic div_last;
		logic last;
		logic out_busy;
	} status_t;

	// q15 sine of table point k, taylor series in q30 with truncated terms
	function automatic logic [15:0] taylor_sine_q15(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		x = (HalfPiQ30 * 64'(k)) / TrigDepth;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		r = (sum + 64'd16384) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return r[15:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int k = 0; k <= TrigDepth; k++) begin
			t[k] = taylor_sine_q15(k);
		end
		return t;
	endfunction

	localparam sine_tab_t SineTab = build_sine_tab();

	// sine of a binary angle, q15, from the quarter-wave table
	function automatic logic signed [16:0] sine_bau(input logic [15:0] a);
		logic [14:0] w;
		logic [TrigProdW-1:0] prod;
		logic [TrigProdW-1:0] idx;
		logic [TrigIdxW-1:0] sel;
		logic signed [16:0] v;
		w = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
		prod = TrigProdW'(w) * TrigProdW'(TrigDepth) + TrigProdW'(8192);
		idx = prod >> 14;
		if (idx > TrigProdW'(TrigDepth)) begin
			idx = TrigProdW'(TrigDepth);
		end
		sel = idx[TrigIdxW-1:0];
		v = $signed({1'b0, SineTab[sel]});
		return a[15] ? -v : v;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/ttcb_ctrl.sv
// sequencer for the ttc brake block: steps one beam through lookup, projection,
// division (for a valid beam with positive projection) and minimum update; uses ttcb_pkg
`default_nettype none
module ttcb_ctrl import ttcb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t stat,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_TRIG;
				end
			end
			ST_TRIG: begin
				cmd.trig = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.dinit = 1'b1;
				state_d = stat.use_div ? ST_DIV : ST_UPD;
			end
			ST_DIV: begin
				cmd.dstep = 1'b1;
				if (stat.div_last) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				// a scan result must wait for the output register to free up
				if (!(stat.last && stat.out_busy)) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/ttcb_dp.sv
// datapath of the ttc brake block: config registers, trig lookup, projection,
// restoring divider, running minimum and output register; uses ttcb_pkg
`default_nettype none
module ttcb_dp import ttcb_pkg::*; #(
	parameter int MAX_BEAMS = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          stat,
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [16:0] cfg_data,
	input  wire logic [15:0] range_mm,
	input  wire logic        range_valid,
	input  wire logic [15:0] vel_x,
	input  wire logic [15:0] vel_y,
	input  wire logic        last_beam,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             brake,
	output logic [16:0]      min_ttc_ms
);

	localparam int IdxW = $clog2(MAX_BEAMS);
	localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_BEAMS - 1);

	logic [15:0] angle_start_q;
	logic [15:0] angle_step_q;
	logic [16:0] threshold_q;

	logic [IdxW-1:0] beam_idx_q;
	logic [16:0] min_q;

	logic [15:0] range_q;
	logic valid_q;
	logic signed [15:0] vx_q;
	logic signed [15:0] vy_q;
	logic last_q;
	logic [15:0] angle_q;
	logic signed [16:0] sin_q;
	logic signed [16:0] cos_q;
	logic signed [32:0] pc_q;
	logic signed [32:0] ps_q;
	logic signed [33:0] proj_q;
	logic take_q;
	logic [DivW:0] rem_q;
	logic [NumW-1:0] quo_q;
	logic [DivCntW-1:0] cnt_q;
	logic out_valid_q;
	logic brake_q;
	logic [16:0] out_min_q;

	logic [15:0] ang_prod;
	logic proj_pos;
	logic [DivW:0] trial;
	logic trial_ok;
	logic [16:0] cand;
	logic [16:0] new_min;

	assign ang_prod = 16'(angle_step_q * beam_idx_q);
	assign proj_pos = !proj_q[33] && (proj_q != '0);
	assign trial = {rem_q[DivW-1:0], quo_q[NumW-1]};
	assign trial_ok = trial >= {1'b0, proj_q[DivW-1:0]};
	assign cand = (quo_q > NumW'(TtcCapMs)) ? TtcCapMs : quo_q[16:0];
	assign new_min = (take_q && (cand < min_q)) ? cand : min_q;

	assign stat.use_div = valid_q && proj_pos;
	assign stat.div_last = cnt_q == DivCntW'(DivSteps - 1);
	assign stat.last = last_q;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign brake = brake_q;
	assign min_ttc_ms = out_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= 16'hA000;
			angle_step_q <= 16'd45;
			threshold_q <= 17'd400;
		end else if (cfg_wen) begin
			case (cfg_idx)
				RegAngleStart: angle_start_q <= cfg_data[15:0];
				RegAngleStep:  angle_step_q <= cfg_data[15:0];
				RegThreshold:  threshold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_idx_q <= '0;
			min_q <= TtcCapMs;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.upd) begin
				if (last_q) begin
					beam_idx_q <= '0;
					min_q <= TtcCapMs;
					out_valid_q <= 1'b1;
				end else begin
					min_q <= new_min;
					if (beam_idx_q != IdxMax) begin
						beam_idx_q <= beam_idx_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			range_q <= range_mm;
			valid_q <= range_valid;
			vx_q <= $signed(vel_x);
			vy_q <= $signed(vel_y);
			last_q <= last_beam;
			angle_q <= angle_start_q + ang_prod;
		end
		if (cmd.trig) begin
			sin_q <= sine_bau(angle_q);
			cos_q <= sine_bau(angle_q + 16'd16384);
		end
		if (cmd.mul) begin
			pc_q <= 33'(cos_q * vx_q);
			ps_q <= 33'(sin_q * vy_q);
		end
		if (cmd.sum) begin
			proj_q <= 34'(pc_q) + 34'(ps_q);
		end
		if (cmd.dinit) begin
			take_q <= valid_q && proj_pos;
			rem_q <= '0;
			quo_q <= (NumW'(range_q) * NumW'(1000)) << 15;
			cnt_q <= '0;
		end
		// one quotient bit per cycle
		if (cmd.dstep) begin
			rem_q <= trial_ok ? (trial - {1'b0, proj_q[DivW-1:0]}) : trial;
			quo_q <= {quo_q[NumW-2:0], trial_ok};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.upd && last_q) begin
			brake_q <= new_min <= threshold_q;
			out_min_q <= new_min;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lidar_ttc_emergency_brake.sv
// time-to-collision emergency brake, one lidar beam word at a time
// each word passes load, lookup, multiply, sum and divider init, then 41 bit-serial divider
// steps if it reaches the divider, then the minimum update; the next word waits until then
// a scan result sits in an output register while the next word is taken
// reset: async active low, clears beam index, running minimum and sequencer
`default_nettype none
module lidar_ttc_emergency_brake import ttcb_pkg::*; #(
	parameter int MAX_BEAMS = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] range_mm,
	input  wire logic        range_valid,
	input  wire logic [15:0] vel_x,
	input  wire logic [15:0] vel_y,
	input  wire logic        last_beam,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             brake,
	output logic [16:0]      min_ttc_ms
);

	cmd_t cmd;
	status_t stat;

	ttcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ttcb_dp #(
		.MAX_BEAMS (MAX_BEAMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.range_mm    (range_mm),
		.range_valid (range_valid),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.last_beam   (last_beam),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.brake       (brake),
		.min_ttc_ms  (min_ttc_ms)
	);

endmodule
`default_nettype wire
